FILE: rtl/block_nesting_matcher_defines.svh
// ---------------------------------------------------------------------------
// block nesting matcher assertion macros
// checks used by the block nesting matcher rtl
// ---------------------------------------------------------------------------
`ifndef BLOCK_NESTING_MATCHER_DEFINES_SVH
`define BLOCK_NESTING_MATCHER_DEFINES_SVH

// same-cycle implication on aclk, off while reset is low
`define BNM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication on aclk, off while reset is low
`define BNM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bnm_pkg.sv
// ---------------------------------------------------------------------------
// bnm_pkg
// word types, codes and helpers of the block nesting matcher
// ---------------------------------------------------------------------------
package bnm_pkg;

    localparam int DEPTH_W = 6;

    localparam logic [2:0] SK_PLAIN = 3'd0;
    localparam logic [2:0] SK_BEGIN = 3'd1;
    localparam logic [2:0] SK_END   = 3'd2;
    localparam logic [2:0] SK_DELIM = 3'd3;
    localparam logic [2:0] SK_EOI   = 3'd4;

    localparam logic [2:0] RK_PASS  = 3'd0;
    localparam logic [2:0] RK_PUSH  = 3'd1;
    localparam logic [2:0] RK_MATCH = 3'd2;
    localparam logic [2:0] RK_SYNTH = 3'd3;
    localparam logic [2:0] RK_BLANK = 3'd4;

    localparam logic [1:0] BE_NONE      = 2'd0;
    localparam logic [1:0] BE_UNMATCHED_END   = 2'd1;
    localparam logic [1:0] BE_UNMATCHED_BEGIN = 2'd2;
    localparam logic [1:0] BE_OVERFLOW  = 2'd3;

    localparam logic [1:0] IE_OK     = 2'd0;
    localparam logic [1:0] IE_SHORT  = 2'd1;
    localparam logic [1:0] IE_EXCESS = 2'd2;

    typedef struct packed {
        logic [2:0]  stmt_kind;
        logic [15:0] block_name;
        logic [7:0]  indent_level;
        logic [31:0] stmt_location;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic [1:0]         block_error;
        logic [31:0]        error_location;
        logic [1:0]         indent_error;
        logic [DEPTH_W-1:0] nesting_depth;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic search;
    } cell_ctrl_t;

    function automatic logic [1:0] indent_check(
        input logic [7:0]         level,
        input logic [DEPTH_W-1:0] depth,
        input logic               closing
    );
        logic [7:0] target;
        target = {{(8-DEPTH_W){1'b0}}, depth};
        if (closing && depth != '0) begin
            target = target - 8'd1;
        end
        if (level < target) begin
            return IE_SHORT;
        end else if (level > target) begin
            return IE_EXCESS;
        end
        return IE_OK;
    endfunction

endpackage

FILE: rtl/block_nesting_matcher.sv
// ---------------------------------------------------------------------------
// block_nesting_matcher
// matches block begin and end statements against a stack of open blocks
// ---------------------------------------------------------------------------
// The open-block stack is a row of STACK_DEPTH cells with the top in cell 0;
// a push or pop shifts the whole row by one entry at once. Plain,
// delimiter and begin words give their result straight from idle. An end word
// first loads the name, then has every cell compare against it, then gives
// its results, where each synthesized end pops one entry per cycle while the
// output is free. End of input drains one open entry per result, and gives no
// result when the stack is empty; a result waiting on m_ready stalls the matcher.
`include "block_nesting_matcher_defines.svh"

module block_nesting_matcher
    import bnm_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_DRAIN  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    in_word_t           req_reg, req_next;
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_word_reg, m_word_next;

    logic               out_free;
    logic               out_load;
    out_word_t          emit;
    cell_ctrl_t         ctrl;
    logic               s_accept;
    logic [DEPTH_W-1:0] depth_dec;
    logic               any_hit;

    logic [15:0] cell_name [STACK_DEPTH];
    logic [31:0] cell_loc  [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] cell_hit;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign s_accept  = s_valid && s_ready;
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign any_hit   = |cell_hit;

    generate
        for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
            logic [15:0] above_name;
            logic [31:0] above_loc;
            logic [15:0] below_name;
            logic [31:0] below_loc;
            logic        below_hit;
            logic        occupied;

            if (i == 0) begin : g_top
                assign above_name = s_word.block_name;
                assign above_loc  = s_word.stmt_location;
            end else begin : g_mid
                assign above_name = cell_name[i-1];
                assign above_loc  = cell_loc[i-1];
            end

            if (i == STACK_DEPTH - 1) begin : g_bottom
                assign below_name = '0;
                assign below_loc  = '0;
                assign below_hit  = 1'b0;
            end else begin : g_inner
                assign below_name = cell_name[i+1];
                assign below_loc  = cell_loc[i+1];
                assign below_hit  = cell_hit[i+1];
            end

            assign occupied = depth_reg > DEPTH_W'(i);

            bnm_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (occupied),
                .key        (req_reg.block_name),
                .above_name (above_name),
                .above_loc  (above_loc),
                .below_name (below_name),
                .below_loc  (below_loc),
                .below_hit  (below_hit),
                .name       (cell_name[i]),
                .loc        (cell_loc[i]),
                .hit        (cell_hit[i])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        depth_next = depth_reg;
        req_next   = req_reg;
        ctrl       = '0;
        out_load   = 1'b0;
        emit       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next = s_word;
                    unique case (s_word.stmt_kind)
                        SK_BEGIN: begin
                            out_load           = 1'b1;
                            emit.result_kind   = RK_PUSH;
                            emit.indent_error  =
                                indent_check(s_word.indent_level, depth_reg, 1'b0);
                            emit.last          = 1'b1;
                            if (depth_reg >= DEPTH_W'(STACK_DEPTH)) begin
                                emit.block_error    = BE_OVERFLOW;
                                emit.error_location = s_word.stmt_location;
                                emit.nesting_depth  = depth_reg;
                            end else begin
                                ctrl.push          = 1'b1;
                                depth_next         = depth_reg + DEPTH_W'(1);
                                emit.nesting_depth = depth_reg + DEPTH_W'(1);
                            end
                        end
                        SK_END: begin
                            state_next = ST_SEARCH;
                        end
                        SK_EOI: begin
                            if (depth_reg != '0) begin
                                state_next = ST_DRAIN;
                            end
                        end
                        default: begin
                            out_load           = 1'b1;
                            emit.result_kind   = RK_PASS;
                            emit.indent_error  = indent_check(s_word.indent_level,
                                depth_reg, s_word.stmt_kind == SK_DELIM);
                            emit.nesting_depth = depth_reg;
                            emit.last          = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                ctrl.search = 1'b1;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    emit.indent_error =
                        indent_check(req_reg.indent_level, depth_reg, 1'b1);
                    if (!any_hit) begin
                        emit.result_kind    = RK_BLANK;
                        emit.block_error    = BE_UNMATCHED_END;
                        emit.error_location = req_reg.stmt_location;
                        emit.nesting_depth  = depth_reg;
                        emit.last           = 1'b1;
                        state_next          = ST_IDLE;
                    end else if (cell_hit[0]) begin
                        ctrl.pop           = 1'b1;
                        depth_next         = depth_dec;
                        emit.result_kind   = RK_MATCH;
                        emit.nesting_depth = depth_dec;
                        emit.last          = 1'b1;
                        state_next         = ST_IDLE;
                    end else begin
                        ctrl.pop            = 1'b1;
                        depth_next          = depth_dec;
                        emit.result_kind    = RK_SYNTH;
                        emit.block_error    = BE_UNMATCHED_BEGIN;
                        emit.error_location = cell_loc[0];
                        emit.nesting_depth  = depth_dec;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    ctrl.pop            = 1'b1;
                    depth_next          = depth_dec;
                    emit.result_kind    = RK_SYNTH;
                    emit.block_error    = BE_UNMATCHED_BEGIN;
                    emit.error_location = cell_loc[0];
                    emit.indent_error   = IE_OK;
                    emit.nesting_depth  = depth_dec;
                    emit.last           = (depth_reg == DEPTH_W'(1));
                    if (depth_reg == DEPTH_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_word_next  = out_load ? emit : m_word_reg;
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    `BNM_ASSERT_NOW(a_depth_bound, 1'b1, depth_reg <= DEPTH_W'(STACK_DEPTH), "stack depth out of range")
    `BNM_ASSERT_NOW(a_ready_idle, s_ready, state_reg == ST_IDLE && out_free, "ready outside idle")
    `BNM_ASSERT_NOW(a_match_last, m_valid && m_word.result_kind == RK_MATCH, m_word.last, "matching end not last")
    `BNM_ASSERT_NEXT(a_full_hold, s_accept && s_word.stmt_kind == SK_BEGIN && depth_reg == DEPTH_W'(STACK_DEPTH), $stable(depth_reg), "push onto full stack moved depth")

endmodule

FILE: rtl/bnm_cell.sv
// ---------------------------------------------------------------------------
// bnm_cell
// one stack entry: name, begin location and search hit, shifting with its
// neighbors on push and pop
// ---------------------------------------------------------------------------
module bnm_cell
    import bnm_pkg::*;
(
    input  logic        aclk,
    input  cell_ctrl_t  ctrl,
    input  logic        occupied,
    input  logic [15:0] key,
    input  logic [15:0] above_name,
    input  logic [31:0] above_loc,
    input  logic [15:0] below_name,
    input  logic [31:0] below_loc,
    input  logic        below_hit,
    output logic [15:0] name,
    output logic [31:0] loc,
    output logic        hit
);

    logic [15:0] name_reg, name_next;
    logic [31:0] loc_reg, loc_next;
    logic        hit_reg, hit_next;

    always_comb begin
        name_next = name_reg;
        loc_next  = loc_reg;
        hit_next  = hit_reg;
        if (ctrl.push) begin
            name_next = above_name;
            loc_next  = above_loc;
            hit_next  = 1'b0;
        end else if (ctrl.pop) begin
            name_next = below_name;
            loc_next  = below_loc;
            hit_next  = below_hit;
        end else if (ctrl.search) begin
            hit_next = occupied && (name_reg == key);
        end
    end

    always_ff @(posedge aclk) begin
        name_reg <= name_next;
        loc_reg  <= loc_next;
        hit_reg  <= hit_next;
    end

    assign name = name_reg;
    assign loc  = loc_reg;
    assign hit  = hit_reg;

endmodule
